// File: src/apostolico_crochemore_matcher_top_defines.svh
// Assertion macros shared by the matcher's checker.
`ifndef APOSTOLICO_CROCHEMORE_MATCHER_TOP_DEFINES_SVH
`define APOSTOLICO_CROCHEMORE_MATCHER_TOP_DEFINES_SVH

// Same-cycle implication under reset.
`define ACM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under reset.
`define ACM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/acm_pkg.sv
// Shared types and codes for the string matcher.
package acm_pkg;

  localparam logic [1:0] FUNC_PAT     = 2'd0;
  localparam logic [1:0] FUNC_TEXT    = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BLD_INIT,
    S_BLD_IN_RD,
    S_BLD_IN_EV,
    S_BLD_STEP,
    S_BLD_TAG,
    S_ELL_RD,
    S_ELL_EV,
    S_CHK_R_RD,
    S_CHK_R_EV,
    S_CHK_L_RD,
    S_CHK_L_EV,
    S_SH_RD,
    S_SH_EV,
    S_EMIT
  } acm_state_t;

  typedef struct packed {
    logic       in_fire;
    logic [1:0] func;
    logic       last;
    logic       rdy;
    logic       chk_hit;
    logic       bp_zero;
    logic       a_lt_m;
    logic       i_lt_m;
    logic       k_lt_ell;
    logic       eq;
    logic       found;
  } acm_stat_t;

  typedef struct packed {
    logic in_ready;
    logic use_ring;
  } acm_ctrl_t;

endpackage

// File: src/acm_fsm.sv
// Sequencer for pattern preprocessing and window checks.
module acm_fsm (
  input  logic                  clk,
  input  logic                  rst_n,
  input  acm_pkg::acm_stat_t    stat,
  output acm_pkg::acm_state_t   state,
  output acm_pkg::acm_ctrl_t    ctrl
);

  acm_pkg::acm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= acm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      acm_pkg::S_IDLE: begin
        if (stat.in_fire) begin
          if (stat.func == acm_pkg::FUNC_PAT && stat.last) begin
            state_nxt = acm_pkg::S_BLD_INIT;
          end else if (stat.func == acm_pkg::FUNC_TEXT && stat.rdy && stat.chk_hit) begin
            state_nxt = acm_pkg::S_CHK_R_RD;
          end
        end
      end
      acm_pkg::S_BLD_INIT:  state_nxt = acm_pkg::S_BLD_IN_RD;
      acm_pkg::S_BLD_IN_RD: state_nxt = stat.bp_zero ? acm_pkg::S_BLD_STEP
                                                     : acm_pkg::S_BLD_IN_EV;
      acm_pkg::S_BLD_IN_EV: state_nxt = stat.eq ? acm_pkg::S_BLD_STEP
                                                : acm_pkg::S_BLD_IN_RD;
      acm_pkg::S_BLD_STEP:  state_nxt = acm_pkg::S_BLD_TAG;
      acm_pkg::S_BLD_TAG:   state_nxt = stat.a_lt_m ? acm_pkg::S_BLD_IN_RD
                                                    : acm_pkg::S_ELL_RD;
      acm_pkg::S_ELL_RD:    state_nxt = stat.a_lt_m ? acm_pkg::S_ELL_EV : acm_pkg::S_IDLE;
      acm_pkg::S_ELL_EV:    state_nxt = stat.eq ? acm_pkg::S_ELL_RD : acm_pkg::S_IDLE;
      acm_pkg::S_CHK_R_RD:  state_nxt = stat.i_lt_m ? acm_pkg::S_CHK_R_EV
                                                    : acm_pkg::S_CHK_L_RD;
      acm_pkg::S_CHK_R_EV:  state_nxt = stat.eq ? acm_pkg::S_CHK_R_RD : acm_pkg::S_SH_RD;
      acm_pkg::S_CHK_L_RD:  state_nxt = stat.k_lt_ell ? acm_pkg::S_CHK_L_EV
                                                      : acm_pkg::S_SH_RD;
      acm_pkg::S_CHK_L_EV:  state_nxt = stat.eq ? acm_pkg::S_CHK_L_RD : acm_pkg::S_SH_RD;
      acm_pkg::S_SH_RD:     state_nxt = acm_pkg::S_SH_EV;
      acm_pkg::S_SH_EV:     state_nxt = stat.found ? acm_pkg::S_EMIT : acm_pkg::S_IDLE;
      acm_pkg::S_EMIT:      state_nxt = acm_pkg::S_IDLE;
      default:              state_nxt = acm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl.in_ready = 1'b0;
    ctrl.use_ring = 1'b0;
    case (state_r)
      acm_pkg::S_IDLE:     ctrl.in_ready = 1'b1;
      acm_pkg::S_CHK_R_EV: ctrl.use_ring = 1'b1;
      acm_pkg::S_CHK_L_EV: ctrl.use_ring = 1'b1;
      default: begin
        ctrl.in_ready = 1'b0;
        ctrl.use_ring = 1'b0;
      end
    endcase
  end

  assign state = state_r;

endmodule

// File: src/apostolico_crochemore_matcher_top.sv
// Top level of the Apostolico-Crochemore exact string matcher.
// A pattern byte is stored as it arrives; the final one also starts the table build,
//   the border steps and then a scan of the leading run of equal bytes.
// A text byte that closes a window is compared byte by byte through the single
//   compare unit, then the shift is taken and any match is emitted.
// Other items stay in idle; a waiting result holds off requests. Reset clears control registers only.
module apostolico_crochemore_matcher_top #(
  parameter int MAX_PATTERN   = 32,
  parameter int POSITION_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_symbol,
  input  logic        in_last_of_pattern,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_match_position
);

  localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
  localparam int RING_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CMP_W  = (POSITION_BITS > LEN_W) ? POSITION_BITS : LEN_W;
  localparam logic [LEN_W:0] MAX_L = (LEN_W + 1)'(MAX_PATTERN);

  // Storage: pattern bytes, tagged borders (stored as border+1), text ring.
  logic [7:0]       pat_mem  [MAX_PATTERN];
  logic [LEN_W-1:0] bt_mem   [MAX_PATTERN + 1];
  logic [7:0]       ring_mem [MAX_PATTERN];

  logic [LEN_W-1:0]         m_r, m_nxt, ell_r, ell_nxt;
  logic                     rdy_r, rdy_nxt;
  logic [RING_W-1:0]        wr_r, wr_nxt, wb_r, wb_nxt;
  logic [POSITION_BITS-1:0] tcnt_r, tcnt_nxt, wst_r, wst_nxt, pos_r, pos_nxt;
  logic [LEN_W-1:0]         i_r, i_nxt, k_r, k_nxt, a_r, a_nxt, bp_r, bp_nxt;
  logic                     found_r, found_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [31:0]              out_pos_r, out_pos_nxt;

  acm_pkg::acm_state_t state;
  acm_pkg::acm_ctrl_t  ctrl;
  acm_pkg::acm_stat_t  stat;

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  // Memory read addresses, one per port and state.
  logic [LEN_W-1:0]  pa_addr, pb_addr, bt_raddr;
  logic [RING_W-1:0] ring_raddr;
  logic [7:0]        pa_q, pb_q, ring_q;
  logic [LEN_W-1:0]  bt_q;
  logic [LEN_W-1:0]  t_sel, i_clamp;
  logic [LEN_W:0]    ridx_sum;

  assign i_clamp = (i_r > m_r) ? m_r : i_r;
  assign t_sel   = (state == acm_pkg::S_CHK_L_RD) ? k_r : i_r;

  // Window offset to ring slot; the sum stays under twice the ring depth.
  always_comb begin
    ridx_sum = (LEN_W + 1)'(wb_r) + (LEN_W + 1)'(t_sel);
    if (ridx_sum >= MAX_L) begin
      ridx_sum = ridx_sum - MAX_L;
    end
    ring_raddr = ridx_sum[RING_W-1:0];
  end

  always_comb begin
    pa_addr  = a_r;
    pb_addr  = bp_r;
    bt_raddr = bp_r;
    case (state)
      acm_pkg::S_BLD_IN_RD: begin
        pb_addr  = bp_r - 1'b1;
        bt_raddr = bp_r - 1'b1;
      end
      acm_pkg::S_BLD_STEP: pa_addr = a_r + 1'b1;
      acm_pkg::S_ELL_RD: begin
        pa_addr = a_r - 1'b1;
        pb_addr = a_r;
      end
      acm_pkg::S_CHK_R_RD: pa_addr = i_r;
      acm_pkg::S_CHK_L_RD: pa_addr = k_r;
      acm_pkg::S_SH_RD:    bt_raddr = i_clamp;
      default: begin
        pa_addr  = a_r;
        pb_addr  = bp_r;
        bt_raddr = bp_r;
      end
    endcase
  end

  // Pattern write: a byte after a finished pattern starts over at slot 0.
  logic [LEN_W-1:0] pw_idx;
  logic             pat_we;
  assign pw_idx = rdy_r ? '0 : m_r;
  assign pat_we = in_fire && (in_func == acm_pkg::FUNC_PAT) &&
                  ((LEN_W + 1)'(pw_idx) < MAX_L);

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[pw_idx[RING_W-1:0]] <= in_symbol;
    end
    pa_q <= pat_mem[pa_addr[RING_W-1:0]];
    pb_q <= pat_mem[pb_addr[RING_W-1:0]];
  end

  logic text_we;
  assign text_we = in_fire && (in_func == acm_pkg::FUNC_TEXT) && rdy_r;

  always_ff @(posedge clk) begin
    if (text_we) begin
      ring_mem[wr_r] <= in_symbol;
    end
    ring_q <= ring_mem[ring_raddr];
  end

  // Shared compare unit: pattern byte against pattern or text byte.
  logic eq;
  assign eq = (pa_q == (ctrl.use_ring ? ring_q : pb_q));

  // Tag write: bt[0] on init, bt[a] on each tagging step.
  logic             bt_we;
  logic [LEN_W-1:0] bt_waddr, bt_wdata;
  always_comb begin
    bt_we    = 1'b0;
    bt_waddr = a_r;
    bt_wdata = bp_r;
    case (state)
      acm_pkg::S_BLD_INIT: begin
        bt_we    = 1'b1;
        bt_waddr = '0;
        bt_wdata = '0;
      end
      acm_pkg::S_BLD_TAG: begin
        bt_we    = 1'b1;
        bt_wdata = (stat.a_lt_m && eq) ? bt_q : bp_r;
      end
      default: bt_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (bt_we) begin
      bt_mem[bt_waddr] <= bt_wdata;
    end
    bt_q <= bt_mem[bt_raddr];
  end

  // Window-complete test for the text byte being accepted.
  logic [POSITION_BITS-1:0] tcnt_inc, win_fill;
  logic [RING_W-1:0]        wr_inc;
  logic [LEN_W:0]           wb_sum;
  assign tcnt_inc = tcnt_r + 1'b1;
  assign win_fill = tcnt_inc - wst_r;
  assign wr_inc   = ((LEN_W + 1)'(wr_r) + 1'b1 >= MAX_L) ? '0 : wr_r + 1'b1;

  always_comb begin
    wb_sum = (LEN_W + 1)'(wr_inc) + (MAX_L - (LEN_W + 1)'(m_r));
    if (wb_sum >= MAX_L) begin
      wb_sum = wb_sum - MAX_L;
    end
  end

  assign stat.in_fire  = in_fire;
  assign stat.func     = in_func;
  assign stat.last     = in_last_of_pattern;
  assign stat.rdy      = rdy_r;
  assign stat.chk_hit  = (CMP_W'(win_fill) == CMP_W'(m_r));
  assign stat.bp_zero  = (bp_r == '0);
  assign stat.a_lt_m   = (a_r < m_r);
  assign stat.i_lt_m   = (i_r < m_r);
  assign stat.k_lt_ell = (k_r < ell_r);
  assign stat.eq       = eq;
  assign stat.found    = found_r;

  acm_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .state (state),
    .ctrl  (ctrl)
  );

  always_comb begin
    m_nxt         = m_r;
    ell_nxt       = ell_r;
    rdy_nxt       = rdy_r;
    wr_nxt        = wr_r;
    wb_nxt        = wb_r;
    tcnt_nxt      = tcnt_r;
    wst_nxt       = wst_r;
    pos_nxt       = pos_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    a_nxt         = a_r;
    bp_nxt        = bp_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_pos_nxt   = out_pos_r;
    case (state)
      acm_pkg::S_IDLE: begin
        if (in_fire) begin
          case (in_func)
            acm_pkg::FUNC_PAT: begin
              if (rdy_r) begin
                rdy_nxt = 1'b0;
                ell_nxt = '0;
              end
              m_nxt = pat_we ? pw_idx + 1'b1 : pw_idx;
            end
            acm_pkg::FUNC_TEXT: begin
              if (rdy_r) begin
                wr_nxt    = wr_inc;
                wb_nxt    = wb_sum[RING_W-1:0];
                tcnt_nxt  = tcnt_inc;
                found_nxt = 1'b0;
              end
            end
            acm_pkg::FUNC_RESTART: begin
              tcnt_nxt = '0;
              wst_nxt  = '0;
              wr_nxt   = '0;
              i_nxt    = ell_r;
              k_nxt    = '0;
            end
            default: m_nxt = m_r;
          endcase
        end
      end
      acm_pkg::S_BLD_INIT: begin
        a_nxt  = '0;
        bp_nxt = '0;
      end
      acm_pkg::S_BLD_IN_EV: begin
        if (!eq) begin
          bp_nxt = bt_q;
        end
      end
      acm_pkg::S_BLD_STEP: begin
        a_nxt  = a_r + 1'b1;
        bp_nxt = bp_r + 1'b1;
      end
      acm_pkg::S_BLD_TAG: begin
        if (!stat.a_lt_m) begin
          a_nxt = LEN_W'(1);
        end
      end
      acm_pkg::S_ELL_RD: begin
        if (!stat.a_lt_m) begin
          // Whole pattern is one run.
          ell_nxt  = '0;
          rdy_nxt  = 1'b1;
          tcnt_nxt = '0;
          wst_nxt  = '0;
          wr_nxt   = '0;
          i_nxt    = '0;
          k_nxt    = '0;
        end
      end
      acm_pkg::S_ELL_EV: begin
        if (eq) begin
          a_nxt = a_r + 1'b1;
        end else begin
          ell_nxt  = a_r;
          rdy_nxt  = 1'b1;
          tcnt_nxt = '0;
          wst_nxt  = '0;
          wr_nxt   = '0;
          i_nxt    = a_r;
          k_nxt    = '0;
        end
      end
      acm_pkg::S_CHK_R_EV: begin
        if (eq) begin
          i_nxt = i_r + 1'b1;
        end
      end
      acm_pkg::S_CHK_L_RD: begin
        if (!stat.k_lt_ell) begin
          found_nxt = 1'b1;
        end
      end
      acm_pkg::S_CHK_L_EV: begin
        if (eq) begin
          k_nxt = k_r + 1'b1;
        end
      end
      acm_pkg::S_SH_RD: i_nxt = i_clamp;
      acm_pkg::S_SH_EV: begin
        // Shift by i - border(i); bt_q holds border(i)+1.
        pos_nxt = wst_r;
        wst_nxt = wst_r + POSITION_BITS'(i_r) + 1'b1 - POSITION_BITS'(bt_q);
        if (i_r == ell_r) begin
          k_nxt = (k_r != '0) ? k_r - 1'b1 : '0;
        end else if ((LEN_W + 1)'(bt_q) <= (LEN_W + 1)'(ell_r) + 1'b1) begin
          k_nxt = (bt_q > LEN_W'(1)) ? bt_q - 1'b1 : '0;
          i_nxt = ell_r;
        end else begin
          k_nxt = ell_r;
          i_nxt = bt_q - 1'b1;
        end
      end
      acm_pkg::S_EMIT: begin
        // Output slot is free: nothing is emitted while another waits in idle.
        out_valid_nxt = 1'b1;
        out_pos_nxt   = 32'(pos_r);
      end
      default: m_nxt = m_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r         <= '0;
      ell_r       <= '0;
      rdy_r       <= 1'b0;
      wr_r        <= '0;
      tcnt_r      <= '0;
      wst_r       <= '0;
      i_r         <= '0;
      k_r         <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      m_r         <= m_nxt;
      ell_r       <= ell_nxt;
      rdy_r       <= rdy_nxt;
      wr_r        <= wr_nxt;
      tcnt_r      <= tcnt_nxt;
      wst_r       <= wst_nxt;
      i_r         <= i_nxt;
      k_r         <= k_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wb_r      <= wb_nxt;
    pos_r     <= pos_nxt;
    a_r       <= a_nxt;
    bp_r      <= bp_nxt;
    out_pos_r <= out_pos_nxt;
  end

  // A pending result holds off new requests so it is never overwritten.
  assign in_ready           = ctrl.in_ready && !out_valid_r;
  assign out_valid          = out_valid_r;
  assign out_match_position = out_pos_r;

endmodule

// File: src/acm_checker.sv
// Port-level checks for the string matcher, bound to the top level.
`include "apostolico_crochemore_matcher_top_defines.svh"

module acm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_match_position
);

  `ACM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_match_position), "result dropped or changed while stalled")
  `ACM_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid), "result raised right after an accepted request")
  `ACM_ASSERT_NOW(a_result_from_busy, $rose(out_valid), $past(!in_ready), "result raised while block was idle")

endmodule

bind apostolico_crochemore_matcher_top acm_checker u_acm_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_match_position (out_match_position)
);
